### hw/rtl/miller_rabin_fixed_base_prime_test_unit_macros.svh
// Assertion macros shared by the prime test unit.
`ifndef MILLER_RABIN_FIXED_BASE_PRIME_TEST_UNIT_MACROS_SVH
`define MILLER_RABIN_FIXED_BASE_PRIME_TEST_UNIT_MACROS_SVH

// Same-cycle implication, checked on clk outside reset.
`define MR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk outside reset.
`define MR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/mr_pkg.sv
// Package with shared types, codes and the witness table of the prime test unit.
`timescale 1ns / 1ps
package mr_pkg;

  localparam int MR_NUM_BITS      = 31;
  localparam int MR_WITNESS_COUNT = 4;
  localparam int MR_WIT_W         = 2;
  localparam int MR_WIT_VAL_W     = 4;

  typedef logic [1:0] mm_op_t;
  localparam mm_op_t OP_REDUCE = 2'd0;  // base = witness mod n
  localparam mm_op_t OP_MUL    = 2'd1;  // acc = acc * base mod n
  localparam mm_op_t OP_SQB    = 2'd2;  // base = base * base mod n
  localparam mm_op_t OP_XSQ    = 2'd3;  // acc = acc * acc mod n

  typedef struct packed {
    logic   load;
    logic   decomp_step;
    logic   mm_start;
    mm_op_t mm_op;
    logic   exp_shift;
    logic   cnt_init;
    logic   cnt_inc;
    logic   next_w;
  } mr_cmd_t;

  typedef struct packed {
    logic n_small;
    logic d_even;
    logic e_zero;
    logic e_lsb;
    logic pass1;
    logic x_nm1;
    logic r_lt_s;
    logic last_w;
    logic mm_busy;
    logic mm_done;
  } mr_status_t;

  function automatic logic [MR_WIT_VAL_W-1:0] witness_value(input logic [MR_WIT_W-1:0] idx);
    logic [MR_WIT_VAL_W-1:0] v;
    case (idx)
      2'd0:    v = 4'd3;
      2'd1:    v = 4'd5;
      2'd2:    v = 4'd7;
      default: v = 4'd11;
    endcase
    return v;
  endfunction

endpackage

### hw/rtl/mr_modmul.sv
// Iterative interleaved modular multiplier, one multiplier bit per cycle.
`timescale 1ns / 1ps
module mr_modmul
  import mr_pkg::*;
#(
  parameter int NUM_BITS = MR_NUM_BITS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [NUM_BITS-1:0] mcand,
  input  logic [NUM_BITS-1:0] mplier,
  input  logic [NUM_BITS-1:0] modulus,
  output logic                busy,
  output logic                done,
  output logic [NUM_BITS-1:0] product
);

  localparam int CW = $clog2(NUM_BITS);

  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic [NUM_BITS-1:0] acc_r, acc_nxt;
  logic [NUM_BITS-1:0] a_r, a_nxt;
  logic [NUM_BITS-1:0] b_r, b_nxt;
  logic [NUM_BITS:0]   t1, t1m, t2, t2m, nx;

  // Double the partial result, then add the multiplicand for the current bit,
  // reducing below the modulus after each step.
  always_comb begin
    nx  = {1'b0, modulus};
    t1  = {acc_r, 1'b0};
    t1m = (t1 >= nx) ? (t1 - nx) : t1;
    t2  = t1m + (b_r[NUM_BITS-1] ? {1'b0, a_r} : '0);
    t2m = (t2 >= nx) ? (t2 - nx) : t2;
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(NUM_BITS - 1);
      acc_nxt  = '0;
      a_nxt    = mcand;
      b_nxt    = mplier;
    end else if (busy_r) begin
      acc_nxt = t2m[NUM_BITS-1:0];
      b_nxt   = {b_r[NUM_BITS-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    acc_r <= acc_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
  end

  assign busy    = busy_r;
  assign done    = done_r;
  assign product = acc_r;

endmodule

### hw/rtl/mr_datapath.sv
// Datapath: candidate, n-1 split, exponent, accumulator, base and witness index.
`timescale 1ns / 1ps
module mr_datapath
  import mr_pkg::*;
#(
  parameter int NUM_BITS = MR_NUM_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [30:0] candidate,
  input  mr_cmd_t     cmd,
  output mr_status_t  st
);

  localparam int SW = $clog2(NUM_BITS);

  logic [NUM_BITS-1:0] n_r, n_nxt;
  logic [NUM_BITS-1:0] d_r, d_nxt;
  logic [NUM_BITS-1:0] e_r, e_nxt;
  logic [NUM_BITS-1:0] acc_r, acc_nxt;
  logic [NUM_BITS-1:0] base_r, base_nxt;
  logic [SW-1:0]       s_r, s_nxt;
  logic [SW-1:0]       cnt_r, cnt_nxt;
  logic [MR_WIT_W-1:0] w_r, w_nxt;
  mm_op_t              sel_r, sel_nxt;

  logic [NUM_BITS-1:0] nm1;
  logic [NUM_BITS-1:0] mm_a, mm_b, mm_p;
  logic                mm_busy, mm_done;

  assign nm1 = n_r - 1'b1;

  always_comb begin
    case (cmd.mm_op)
      OP_REDUCE: begin
        mm_a = NUM_BITS'(1);
        mm_b = NUM_BITS'(witness_value(w_r));
      end
      OP_MUL: begin
        mm_a = base_r;
        mm_b = acc_r;
      end
      OP_SQB: begin
        mm_a = base_r;
        mm_b = base_r;
      end
      default: begin
        mm_a = acc_r;
        mm_b = acc_r;
      end
    endcase
  end

  mr_modmul #(.NUM_BITS(NUM_BITS)) u_modmul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.mm_start),
    .mcand   (mm_a),
    .mplier  (mm_b),
    .modulus (n_r),
    .busy    (mm_busy),
    .done    (mm_done),
    .product (mm_p)
  );

  always_comb begin
    n_nxt    = n_r;
    d_nxt    = d_r;
    e_nxt    = e_r;
    acc_nxt  = acc_r;
    base_nxt = base_r;
    s_nxt    = s_r;
    cnt_nxt  = cnt_r;
    w_nxt    = w_r;
    sel_nxt  = sel_r;
    if (cmd.load) begin
      n_nxt = candidate[NUM_BITS-1:0];
      d_nxt = candidate[NUM_BITS-1:0] - 1'b1;
      s_nxt = '0;
      w_nxt = '0;
    end
    if (cmd.decomp_step) begin
      d_nxt = {1'b0, d_r[NUM_BITS-1:1]};
      s_nxt = s_r + 1'b1;
    end
    if (cmd.mm_start) begin
      sel_nxt = cmd.mm_op;
      if (cmd.mm_op == OP_REDUCE) begin
        acc_nxt = NUM_BITS'(1);
        e_nxt   = d_r;
      end
    end
    if (mm_done) begin
      case (sel_r)
        OP_REDUCE: base_nxt = mm_p;
        OP_MUL:    acc_nxt  = mm_p;
        OP_SQB:    base_nxt = mm_p;
        default:   acc_nxt  = mm_p;
      endcase
    end
    if (cmd.exp_shift) e_nxt = {1'b0, e_r[NUM_BITS-1:1]};
    if (cmd.cnt_init) cnt_nxt = SW'(1);
    if (cmd.cnt_inc) cnt_nxt = cnt_r + 1'b1;
    if (cmd.next_w) w_nxt = w_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    n_r    <= n_nxt;
    d_r    <= d_nxt;
    e_r    <= e_nxt;
    acc_r  <= acc_nxt;
    base_r <= base_nxt;
    s_r    <= s_nxt;
    cnt_r  <= cnt_nxt;
    w_r    <= w_nxt;
    sel_r  <= sel_nxt;
  end

  always_comb begin
    st.n_small = (n_r < NUM_BITS'(2));
    st.d_even  = ~d_r[0];
    st.e_zero  = (e_r == '0);
    st.e_lsb   = e_r[0];
    st.x_nm1   = (acc_r == nm1);
    st.pass1   = (acc_r == NUM_BITS'(1)) || (acc_r == nm1);
    st.r_lt_s  = (cnt_r < s_r);
    st.last_w  = (w_r == MR_WIT_W'(MR_WITNESS_COUNT - 1));
    st.mm_busy = mm_busy;
    st.mm_done = mm_done;
  end

endmodule

### hw/rtl/mr_ctrl.sv
// Controller state machine and output register of the prime test unit.
`timescale 1ns / 1ps
`include "miller_rabin_fixed_base_prime_test_unit_macros.svh"
module mr_ctrl
  import mr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic       out_prime,
  output logic       out_invalid,
  output mr_cmd_t    cmd,
  input  mr_status_t st
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CHK    = 4'd1;
  localparam logic [3:0] S_DECOMP = 4'd2;
  localparam logic [3:0] S_RED_GO = 4'd3;
  localparam logic [3:0] S_RED_W  = 4'd4;
  localparam logic [3:0] S_EXP    = 4'd5;
  localparam logic [3:0] S_MUL_W  = 4'd6;
  localparam logic [3:0] S_SQB_GO = 4'd7;
  localparam logic [3:0] S_SQB_W  = 4'd8;
  localparam logic [3:0] S_TEST   = 4'd9;
  localparam logic [3:0] S_SQ     = 4'd10;
  localparam logic [3:0] S_SQ_W   = 4'd11;
  localparam logic [3:0] S_SQ_CHK = 4'd12;
  localparam logic [3:0] S_NEXT   = 4'd13;
  localparam logic [3:0] S_DONE   = 4'd14;

  logic [3:0] state_r, state_nxt;
  logic       res_prime_r, res_prime_nxt;
  logic       res_inv_r, res_inv_nxt;
  logic       ovalid_r, ovalid_nxt;
  logic       oprime_r, oprime_nxt;
  logic       oinv_r, oinv_nxt;
  logic       out_free;

  assign out_free  = !ovalid_r || out_tready;
  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    res_prime_nxt = res_prime_r;
    res_inv_nxt   = res_inv_r;
    ovalid_nxt    = ovalid_r && !out_tready;
    oprime_nxt    = oprime_r;
    oinv_nxt      = oinv_r;
    cmd           = '0;
    cmd.mm_op     = OP_REDUCE;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        if (st.n_small) begin
          res_prime_nxt = 1'b0;
          res_inv_nxt   = 1'b1;
          state_nxt     = S_DONE;
        end else begin
          state_nxt = S_DECOMP;
        end
      end
      S_DECOMP: begin
        if (st.d_even) cmd.decomp_step = 1'b1;
        else state_nxt = S_RED_GO;
      end
      S_RED_GO: begin
        cmd.mm_start = 1'b1;
        cmd.mm_op    = OP_REDUCE;
        state_nxt    = S_RED_W;
      end
      S_RED_W: begin
        if (st.mm_done) state_nxt = S_EXP;
      end
      S_EXP: begin
        if (st.e_zero) begin
          state_nxt = S_TEST;
        end else if (st.e_lsb) begin
          cmd.mm_start = 1'b1;
          cmd.mm_op    = OP_MUL;
          state_nxt    = S_MUL_W;
        end else begin
          state_nxt = S_SQB_GO;
        end
      end
      S_MUL_W: begin
        if (st.mm_done) state_nxt = S_SQB_GO;
      end
      S_SQB_GO: begin
        cmd.mm_start = 1'b1;
        cmd.mm_op    = OP_SQB;
        state_nxt    = S_SQB_W;
      end
      S_SQB_W: begin
        if (st.mm_done) begin
          cmd.exp_shift = 1'b1;
          state_nxt     = S_EXP;
        end
      end
      S_TEST: begin
        if (st.pass1) begin
          state_nxt = S_NEXT;
        end else begin
          cmd.cnt_init = 1'b1;
          state_nxt    = S_SQ;
        end
      end
      S_SQ: begin
        if (st.r_lt_s) begin
          cmd.mm_start = 1'b1;
          cmd.mm_op    = OP_XSQ;
          state_nxt    = S_SQ_W;
        end else begin
          res_prime_nxt = 1'b0;
          res_inv_nxt   = 1'b0;
          state_nxt     = S_DONE;
        end
      end
      S_SQ_W: begin
        if (st.mm_done) begin
          cmd.cnt_inc = 1'b1;
          state_nxt   = S_SQ_CHK;
        end
      end
      S_SQ_CHK: begin
        state_nxt = st.x_nm1 ? S_NEXT : S_SQ;
      end
      S_NEXT: begin
        if (st.last_w) begin
          res_prime_nxt = 1'b1;
          res_inv_nxt   = 1'b0;
          state_nxt     = S_DONE;
        end else begin
          cmd.next_w = 1'b1;
          state_nxt  = S_RED_GO;
        end
      end
      S_DONE: begin
        if (out_free) begin
          ovalid_nxt = 1'b1;
          oprime_nxt = res_prime_r;
          oinv_nxt   = res_inv_r;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
    res_prime_r <= res_prime_nxt;
    res_inv_r   <= res_inv_nxt;
    oprime_r    <= oprime_nxt;
    oinv_r      <= oinv_nxt;
  end

  assign out_tvalid  = ovalid_r;
  assign out_prime   = oprime_r;
  assign out_invalid = oinv_r;

  `MR_ASSERT_NOW(a_inv_not_prime, ovalid_r && oinv_r, !oprime_r, "invalid beat flagged prime")
  `MR_ASSERT_NOW(a_start_idle_mm, cmd.mm_start, !st.mm_busy, "multiply started while busy")
  `MR_ASSERT_NEXT(a_accept_chk, in_tvalid && in_tready, state_r == S_CHK, "accept not followed by check")
  `MR_ASSERT_NOW(a_done_in_wait, st.mm_done, state_r == S_RED_W || state_r == S_MUL_W ||
                 state_r == S_SQB_W || state_r == S_SQ_W, "multiply finished outside a wait state")

endmodule

### hw/rtl/miller_rabin_fixed_base_prime_test_unit.sv
// Top level of the fixed-witness Miller-Rabin prime test unit.
`timescale 1ns / 1ps
// One candidate is taken per in_ beat and one result beat comes back for it. Inputs below two
// return invalid_input set. Otherwise the unit tests witnesses 3, 5, 7 and 11 in turn and stops
// at the first that fails. Every modular multiply runs on one shared bit-serial multiplier, so
// an item takes roughly (witnesses tried) x (about 1.5 x NUM_BITS + s) multiplies. A new
// candidate is taken once the previous result sits in the output register.
module miller_rabin_fixed_base_prime_test_unit
  import mr_pkg::*;
#(
  parameter int NUM_BITS = MR_NUM_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [30:0] candidate
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata   // [0] probable_prime, [1] invalid_input
);

  mr_cmd_t    cmd;
  mr_status_t st;
  logic       prime, invalid;

  mr_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_prime   (prime),
    .out_invalid (invalid),
    .cmd         (cmd),
    .st          (st)
  );

  mr_datapath #(.NUM_BITS(NUM_BITS)) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .candidate (in_tdata[30:0]),
    .cmd       (cmd),
    .st        (st)
  );

  assign out_tdata = {6'b0, invalid, prime};

endmodule
